// ===== sv/assert_macros.svh =====
// Assertion macros shared by the edge sharpen filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ESF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edge sharpen filter check failed");

// next-cycle implication
`define ESF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edge sharpen filter check failed");

`endif

// ===== sv/esf_pkg.sv =====
// Package for the edge sharpen 3x3 stream filter: sizes, codes and types.
// No dependencies; used by every module of the block except esf_ram.
`default_nettype none

package esf_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int POS_W      = 9;
    localparam int CFG_W      = 10;
    localparam int IDX_W      = 2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [COL_W-1:0] col_idx_t;
    typedef logic [ROW_W-1:0] row_idx_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CFG_W-1:0] cfg_data_t;
    typedef logic [IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FILTER_MODE  = 2'd0;
    localparam cfg_idx_t CFG_FRAME_WIDTH  = 2'd1;
    localparam cfg_idx_t CFG_FRAME_HEIGHT = 2'd2;

    localparam cfg_data_t CFG_SIZE_RESET = 10'd512;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic MODE_SHARPEN = 1'b0;
    localparam logic MODE_SOBEL_X = 1'b1;

    // one window column: top, middle and bottom taps
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } tap_col_t;

endpackage

`default_nettype wire

// ===== sv/esf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced twice for the two line buffers of the filter.
`default_nettype none

module esf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/esf_col_cell.sv =====
// One column cell of the 3x3 window chain: holds three taps.
// Depends on esf_pkg for the column type.
`default_nettype none

module esf_col_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              restart,
    input  wire esf_pkg::tap_col_t neighbor,
    input  wire esf_pkg::tap_col_t fresh,
    output esf_pkg::tap_col_t      col_q
);

    esf_pkg::tap_col_t col_reg;
    esf_pkg::tap_col_t col_next;

    // replicate the new column at the left border, else take the neighbor's
    always_comb
    begin
        col_next = col_reg;
        if (en)
        begin
            col_next = restart ? fresh : neighbor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_q = col_reg;

endmodule

`default_nettype wire

// ===== sv/esf_kernel.sv =====
// Sharpen / Sobel X kernel over three window columns, clamped to 0..255.
// Depends on esf_pkg for the column type and mode codes.
`default_nettype none

module esf_kernel (
    input  wire logic              mode,
    input  wire esf_pkg::tap_col_t left,
    input  wire esf_pkg::tap_col_t center,
    input  wire esf_pkg::tap_col_t right,
    output esf_pkg::pix_t          result
);

    logic        [11:0] pos_sum;
    logic        [11:0] neg_sum;
    logic signed [12:0] acc;

    always_comb
    begin
        case (mode)
            esf_pkg::MODE_SHARPEN:
            begin
                pos_sum = {1'b0, center.mid, 3'b000} + {4'b0000, center.mid};
                neg_sum = {4'b0000, left.top} + {4'b0000, left.mid}
                        + {4'b0000, left.bot} + {4'b0000, center.top}
                        + {4'b0000, center.bot} + {4'b0000, right.top}
                        + {4'b0000, right.mid} + {4'b0000, right.bot};
            end
            esf_pkg::MODE_SOBEL_X:
            begin
                pos_sum = {4'b0000, right.top} + {3'b000, right.mid, 1'b0}
                        + {4'b0000, right.bot};
                neg_sum = {4'b0000, left.top} + {3'b000, left.mid, 1'b0}
                        + {4'b0000, left.bot};
            end
            default:
            begin
                pos_sum = '0;
                neg_sum = '0;
            end
        endcase
        acc = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
        if (acc[12])
        begin
            result = '0;
        end
        else if (|acc[11:8])
        begin
            result = 8'hFF;
        end
        else
        begin
            result = acc[7:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/edge_sharpen_3x3_stream_filter_core.sv =====
// Top level of the edge sharpen 3x3 stream filter: counters, line buffers,
// window chain, result sequencer. Depends on esf_pkg, esf_ram, esf_col_cell,
// esf_kernel and assert_macros.svh.
//
// Usage:
//   Input words (kind, pixel_in) arrive in raster order on in_valid/in_stall;
//   kind 0 is a pixel, kind 1 a flush word that drains one column of the
//   bottom row after the last pixel of a frame. Output words (pixel_out,
//   out_row, out_col, frame_done) leave on out_valid/out_stall; images lag
//   the input by one row, and frame_done marks the last pixel of the frame.
//   Each word passes the read stage, the window stage and the output
//   register. Throughput: one word per cycle while out_stall stays low;
//   the last column of each result row makes two result words through the
//   single output register, so the input can stall at a row end.
//   Reset clears counters, window and configuration (sharpen, 512 x 512);
//   line buffers are not cleared, the first rows of a frame fill them.
//   Write configuration only while the block is idle.
//   When the receiver stalls, the output word holds, the window stage and
//   the read stage fill, then in_stall rises; no word is lost.
`default_nettype none
`include "assert_macros.svh"

module edge_sharpen_3x3_stream_filter_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 kind,
    input  wire esf_pkg::pix_t        pixel_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output esf_pkg::pix_t             pixel_out,
    output esf_pkg::pos_t             out_row,
    output esf_pkg::pos_t             out_col,
    output logic                      frame_done,
    input  wire logic                 cfg_we,
    input  wire esf_pkg::cfg_idx_t    cfg_index,
    input  wire esf_pkg::cfg_data_t   cfg_data
);

    // configuration
    logic               filter_mode_reg;
    esf_pkg::cfg_data_t frame_width_reg;
    esf_pkg::cfg_data_t frame_height_reg;
    esf_pkg::col_idx_t  w_last;
    esf_pkg::row_idx_t  h_last;

    // position counters
    esf_pkg::col_idx_t  in_col_reg, in_col_next;
    esf_pkg::row_idx_t  in_row_reg, in_row_next;
    esf_pkg::col_idx_t  drain_col_reg, drain_col_next;
    logic               drain_active_reg, drain_active_next;

    // accept stage
    logic               in_accept;
    esf_pkg::col_idx_t  c_cl, d_cl;
    esf_pkg::row_idx_t  r_cl;
    logic               a_live, a_first, a_tail, a_done, a_frame_end;
    esf_pkg::col_idx_t  a_addr;
    esf_pkg::row_idx_t  a_row;

    // read stage
    logic               rd_valid_reg, rd_valid_next;
    logic               rd_pixel_reg, rd_top_rep_reg;
    logic               rd_first_reg, rd_tail_reg, rd_done_reg;
    esf_pkg::pix_t      rd_px_reg;
    esf_pkg::col_idx_t  rd_addr_reg;
    esf_pkg::row_idx_t  rd_row_reg;
    logic               rd_adv;
    logic               line_we;
    esf_pkg::pix_t      older_rdata, newer_rdata;
    esf_pkg::tap_col_t  fresh_col;

    // window stage
    logic               win_first_reg, win_first_next;
    logic               win_tail_reg, win_tail_next;
    logic               win_done_reg;
    esf_pkg::row_idx_t  win_row_reg;
    esf_pkg::col_idx_t  win_col_reg;
    logic               win_busy, win_free, win_sel_tail;
    esf_pkg::tap_col_t  win_col [3];
    esf_pkg::tap_col_t  k_left, k_center;
    esf_pkg::pix_t      k_result;

    // output register
    logic               load;
    logic               out_valid_reg, out_valid_next;
    esf_pkg::pix_t      pixel_out_reg;
    esf_pkg::pos_t      out_row_reg, out_col_reg;
    logic               frame_done_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg  <= esf_pkg::MODE_SHARPEN;
            frame_width_reg  <= esf_pkg::CFG_SIZE_RESET;
            frame_height_reg <= esf_pkg::CFG_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esf_pkg::CFG_FILTER_MODE:  filter_mode_reg  <= cfg_data[0];
                esf_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                esf_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // saturate sizes and take the last index
    always_comb
    begin
        if (frame_width_reg < 10'd2)
        begin
            w_last = esf_pkg::col_idx_t'(1);
        end
        else if (32'(frame_width_reg) > esf_pkg::MAX_WIDTH)
        begin
            w_last = esf_pkg::col_idx_t'(esf_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            w_last = esf_pkg::col_idx_t'(frame_width_reg - 10'd1);
        end
        if (frame_height_reg < 10'd2)
        begin
            h_last = esf_pkg::row_idx_t'(1);
        end
        else if (32'(frame_height_reg) > esf_pkg::MAX_HEIGHT)
        begin
            h_last = esf_pkg::row_idx_t'(esf_pkg::MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = esf_pkg::row_idx_t'(frame_height_reg - 10'd1);
        end
    end

    // ---------------- handshake ----------------
    assign load      = !out_valid_reg || !out_stall;
    assign win_busy  = win_first_reg || win_tail_reg;
    assign win_free  = !win_busy || (load && !(win_first_reg && win_tail_reg));
    assign rd_adv    = rd_valid_reg && win_free;
    assign in_stall  = rd_valid_reg && !win_free;
    assign in_accept = in_valid && !in_stall;

    // ---------------- accept stage ----------------
    always_comb
    begin
        c_cl = (in_col_reg > w_last) ? w_last : in_col_reg;
        r_cl = (in_row_reg > h_last) ? h_last : in_row_reg;
        d_cl = (drain_col_reg > w_last) ? w_last : drain_col_reg;

        a_live      = 1'b0;
        a_first     = 1'b0;
        a_tail      = 1'b0;
        a_done      = 1'b0;
        a_addr      = c_cl;
        a_row       = r_cl - esf_pkg::row_idx_t'(1);
        a_frame_end = (c_cl == w_last) && (r_cl == h_last);

        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        drain_col_next    = drain_col_reg;
        drain_active_next = drain_active_reg;

        if (kind == esf_pkg::KIND_PIXEL)
        begin
            a_live            = 1'b1;
            a_first           = (r_cl != '0) && (c_cl != '0);
            a_tail            = (r_cl != '0) && (c_cl == w_last);
            drain_active_next = 1'b0;
            if (c_cl == w_last)
            begin
                in_col_next = '0;
                if (r_cl == h_last)
                begin
                    in_row_next       = '0;
                    drain_active_next = 1'b1;
                    drain_col_next    = '0;
                end
                else
                begin
                    in_row_next = r_cl + esf_pkg::row_idx_t'(1);
                end
            end
            else
            begin
                in_col_next = c_cl + esf_pkg::col_idx_t'(1);
            end
        end
        else
        begin
            a_live  = drain_active_reg;
            a_addr  = d_cl;
            a_first = (d_cl != '0);
            a_tail  = (d_cl == w_last);
            a_row   = h_last;
            a_done  = 1'b1;
            if (drain_active_reg)
            begin
                if (d_cl == w_last)
                begin
                    drain_active_next = 1'b0;
                    drain_col_next    = '0;
                end
                else
                begin
                    drain_col_next = d_cl + esf_pkg::col_idx_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            drain_col_reg    <= '0;
            drain_active_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            drain_col_reg    <= drain_col_next;
            drain_active_reg <= drain_active_next;
        end
    end

    // ---------------- read stage ----------------
    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (in_accept)
        begin
            rd_valid_next = a_live;
        end
        else if (rd_adv)
        begin
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_pixel_reg   <= (kind == esf_pkg::KIND_PIXEL);
            rd_top_rep_reg <= (r_cl <= esf_pkg::row_idx_t'(1));
            rd_first_reg   <= a_first;
            rd_tail_reg    <= a_tail;
            rd_done_reg    <= a_done;
            rd_px_reg      <= pixel_in;
            rd_addr_reg    <= a_addr;
            rd_row_reg     <= a_row;
        end
    end

    assign line_we = rd_adv && rd_pixel_reg;

    esf_ram #(
        .WIDTH (esf_pkg::PIX_W),
        .DEPTH (esf_pkg::MAX_WIDTH)
    ) u_older_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (rd_addr_reg),
        .wdata (newer_rdata),
        .re    (in_accept),
        .raddr (a_addr),
        .rdata (older_rdata)
    );

    esf_ram #(
        .WIDTH (esf_pkg::PIX_W),
        .DEPTH (esf_pkg::MAX_WIDTH)
    ) u_newer_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (rd_addr_reg),
        .wdata (rd_px_reg),
        .re    (in_accept),
        .raddr (a_addr),
        .rdata (newer_rdata)
    );

    // replicate top border rows; flush words replicate the bottom row
    always_comb
    begin
        fresh_col.mid = newer_rdata;
        fresh_col.top = (rd_pixel_reg && rd_top_rep_reg) ? newer_rdata : older_rdata;
        fresh_col.bot = rd_pixel_reg ? rd_px_reg : newer_rdata;
    end

    // ---------------- window chain ----------------
    for (genvar k = 0; k < 3; k++)
    begin : g_cell
        esf_col_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (rd_adv),
            .restart  (rd_addr_reg == '0),
            .neighbor ((k == 2) ? fresh_col : win_col[(k == 2) ? k : k + 1]),
            .fresh    (fresh_col),
            .col_q    (win_col[k])
        );
    end

    // ---------------- result sequencer ----------------
    always_comb
    begin
        win_first_next = win_first_reg;
        win_tail_next  = win_tail_reg;
        if (rd_adv)
        begin
            win_first_next = rd_first_reg;
            win_tail_next  = rd_tail_reg;
        end
        else if (load)
        begin
            if (win_first_reg)
            begin
                win_first_next = 1'b0;
            end
            else
            begin
                win_tail_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_first_reg <= 1'b0;
            win_tail_reg  <= 1'b0;
        end
        else
        begin
            win_first_reg <= win_first_next;
            win_tail_reg  <= win_tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_adv)
        begin
            win_done_reg <= rd_done_reg;
            win_row_reg  <= rd_row_reg;
            win_col_reg  <= rd_addr_reg;
        end
    end

    // tail result drops the left column and repeats the right one
    assign win_sel_tail = !win_first_reg;
    assign k_left       = win_sel_tail ? win_col[1] : win_col[0];
    assign k_center     = win_sel_tail ? win_col[2] : win_col[1];

    esf_kernel u_kernel (
        .mode   (filter_mode_reg),
        .left   (k_left),
        .center (k_center),
        .right  (win_col[2]),
        .result (k_result)
    );

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = win_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_out_reg  <= k_result;
            out_row_reg    <= esf_pkg::pos_t'(win_row_reg);
            out_col_reg    <= win_sel_tail ? esf_pkg::pos_t'(win_col_reg)
                                           : esf_pkg::pos_t'(win_col_reg
                                                 - esf_pkg::col_idx_t'(1));
            frame_done_reg <= win_sel_tail && win_done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_done = frame_done_reg;

    // ---------------- checks ----------------
    `ESF_ASSERT_IMP(a_line_hazard, clk, rst_n, line_we && in_accept && a_live, rd_addr_reg != a_addr)
    `ESF_ASSERT_IMP(a_push_when_free, clk, rst_n, rd_adv, !(win_first_reg && win_tail_reg))
    `ESF_ASSERT_IMP(a_done_last_col, clk, rst_n, out_valid_reg && frame_done_reg, out_col_reg == esf_pkg::pos_t'(w_last))
    `ESF_ASSERT_NXT(a_drain_arm, clk, rst_n, in_accept && (kind == esf_pkg::KIND_PIXEL) && a_frame_end, drain_active_reg)

endmodule

`default_nettype wire

// ===== verif/tb_edge_sharpen_3x3_stream_filter_core.sv =====
// Self-checking testbench for edge_sharpen_3x3_stream_filter_core: directed
// frames, then random frames, with a scoreboard that predicts every word.
// Depends on esf_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb_edge_sharpen_3x3_stream_filter_core;

    import esf_pkg::*;

    localparam int          ITEM_GOAL     = 550;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 150;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam cfg_idx_t    CFG_UNUSED    = 2'd3;

    typedef struct packed {
        pix_t level;
        pos_t row;
        pos_t col;
        logic last;
    } filt_word_t;

    class sharpen_scoreboard;
        logic         mode_q;
        cfg_data_t    width_q;
        cfg_data_t    height_q;
        pix_t         upper_buf [MAX_WIDTH];
        pix_t         prev_buf [MAX_WIDTH];
        pix_t         win [9];
        int unsigned  row_q;
        int unsigned  col_q;
        int unsigned  drain_q;
        bit           drain_pending;
        filt_word_t   pending_pixels [$];
        int unsigned  mismatches;

        function new();
            mode_q = MODE_SHARPEN;
            width_q = CFG_SIZE_RESET;
            height_q = CFG_SIZE_RESET;
            foreach (upper_buf[i])
            begin
                upper_buf[i] = '0;
                prev_buf[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            row_q = 0;
            col_q = 0;
            drain_q = 0;
            drain_pending = 1'b0;
            mismatches = 0;
        endfunction

        function int unsigned clamp_size(cfg_data_t v, int unsigned lim);
            if (v < 2)
                return 2;
            if (v > lim)
                return lim;
            return int'(v);
        endfunction

        function int unsigned cur_width();
            return clamp_size(width_q, MAX_WIDTH);
        endfunction

        function void apply_reg(cfg_idx_t idx, cfg_data_t data);
            if (idx == CFG_FILTER_MODE)
                mode_q = data[0];
            else if (idx == CFG_FRAME_WIDTH)
                width_q = data;
            else if (idx == CFG_FRAME_HEIGHT)
                height_q = data;
        endfunction

        function void shift_in(int unsigned c, pix_t t, pix_t m, pix_t b);
            for (int k = 0; k < 3; k++)
            begin
                if (c != 0)
                begin
                    win[3*k]   = win[3*k+1];
                    win[3*k+1] = win[3*k+2];
                end
            end
            win[2] = t;
            win[5] = m;
            win[8] = b;
            if (c == 0)
            begin
                win[0] = t;
                win[1] = t;
                win[3] = m;
                win[4] = m;
                win[6] = b;
                win[7] = b;
            end
        endfunction

        function pix_t filter_level(pix_t w [9]);
            int acc;
            if (mode_q == MODE_SHARPEN)
            begin
                acc = 10 * int'(w[4]);
                for (int k = 0; k < 9; k++)
                    acc = acc - int'(w[k]);
            end
            else
            begin
                acc = int'(w[2]) + 2 * int'(w[5]) + int'(w[8])
                    - int'(w[0]) - 2 * int'(w[3]) - int'(w[6]);
            end
            if (acc > 255)
                acc = 255;
            if (acc < 0)
                acc = 0;
            return pix_t'(acc);
        endfunction

        function void push_words(int unsigned c, int unsigned w, int unsigned row,
                                 logic last);
            pix_t       tail [9];
            filt_word_t fw;
            if (c >= 1)
            begin
                fw.level = filter_level(win);
                fw.row = pos_t'(row);
                fw.col = pos_t'(c - 1);
                fw.last = 1'b0;
                pending_pixels.push_back(fw);
            end
            if (c == w - 1)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    tail[3*k]   = win[3*k+1];
                    tail[3*k+1] = win[3*k+2];
                    tail[3*k+2] = win[3*k+2];
                end
                fw.level = filter_level(tail);
                fw.row = pos_t'(row);
                fw.col = pos_t'(w - 1);
                fw.last = last;
                pending_pixels.push_back(fw);
            end
        endfunction

        function void note_input(logic k, pix_t px);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            pix_t        t;
            pix_t        m;
            w = clamp_size(width_q, MAX_WIDTH);
            h = clamp_size(height_q, MAX_HEIGHT);
            if (k == KIND_FLUSH)
            begin
                if (!drain_pending)
                    return;
                c = (drain_q > w - 1) ? w - 1 : drain_q;
                t = upper_buf[c];
                m = prev_buf[c];
                shift_in(c, t, m, m);
                push_words(c, w, h - 1, 1'b1);
                if (c == w - 1)
                begin
                    drain_pending = 1'b0;
                    drain_q = 0;
                end
                else
                    drain_q = c + 1;
            end
            else
            begin
                drain_pending = 1'b0;
                r = (row_q > h - 1) ? h - 1 : row_q;
                c = (col_q > w - 1) ? w - 1 : col_q;
                m = prev_buf[c];
                t = (r <= 1) ? m : upper_buf[c];
                upper_buf[c] = m;
                prev_buf[c] = px;
                shift_in(c, t, m, px);
                if (r >= 1)
                    push_words(c, w, r - 1, 1'b0);
                if (c == w - 1)
                begin
                    col_q = 0;
                    if (r == h - 1)
                    begin
                        row_q = 0;
                        drain_pending = 1'b1;
                        drain_q = 0;
                    end
                    else
                        row_q = r + 1;
                end
                else
                    col_q = c + 1;
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("ERROR: %s", msg);
        endtask

        task check_result(pix_t lv, pos_t r, pos_t c, logic ld);
            filt_word_t e;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("unexpected word level %0d row %0d col %0d done %0b",
                                 lv, r, c, ld));
                return;
            end
            e = pending_pixels.pop_front();
            if (lv !== e.level || r !== e.row || c !== e.col || ld !== e.last)
                report($sformatf({"got level %0d row %0d col %0d done %0b, ",
                                  "want level %0d row %0d col %0d done %0b"},
                                 lv, r, c, ld, e.level, e.row, e.col, e.last));
        endtask

        task close_out();
            if (pending_pixels.size() != 0)
                report($sformatf("%0d expected words never arrived",
                                 pending_pixels.size()));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = KIND_PIXEL;
    pix_t        pixel_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    pix_t        pixel_out;
    pos_t        out_row;
    pos_t        out_col;
    logic        frame_done;
    logic        cfg_we = 1'b0;
    cfg_idx_t    cfg_index = CFG_FILTER_MODE;
    cfg_data_t   cfg_data = '0;

    logic        steady = 1'b0;
    logic        hold_go = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    bit          tally_on = 1'b0;
    int          tally = 0;
    int unsigned cycle_count = 0;

    sharpen_scoreboard sb = new();

    edge_sharpen_3x3_stream_filter_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_done (frame_done),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (steady)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 16);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(pixel_out, out_row, out_col, frame_done);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic pix_t rand_pixel();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    task automatic send_word(logic k, pix_t px);
        while (!steady && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (tally_on && (k == KIND_PIXEL || sb.drain_pending))
            tally++;
        in_valid <= 1'b1;
        kind <= k;
        pixel_in <= px;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(k, px);
    endtask

    // drop valid, wait for every expected word, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.apply_reg(idx, data);
    endtask

    task automatic set_config(logic m, cfg_data_t w, cfg_data_t h);
        write_reg(CFG_FILTER_MODE, cfg_data_t'(m));
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame();
        do
        begin
            if ($urandom_range(99) < 5 && !sb.drain_pending)
                send_word(KIND_FLUSH, rand_pixel());
            send_word(KIND_PIXEL, rand_pixel());
        end
        while (!sb.drain_pending);
    endtask

    task automatic run_phase(logic m, cfg_data_t w, cfg_data_t h, int frames);
        int cut;
        set_config(m, w, h);
        for (int f = 0; f < frames; f++)
        begin
            send_frame();
            if (f == frames - 1 || $urandom_range(99) < 75)
            begin
                while (sb.drain_pending)
                    send_word(KIND_FLUSH, rand_pixel());
                repeat ($urandom_range(2)) send_word(KIND_FLUSH, rand_pixel());
            end
            else
            begin
                cut = $urandom_range(sb.cur_width() - 1);
                repeat (cut) send_word(KIND_FLUSH, rand_pixel());
            end
        end
        settle();
    endtask

    // shrink width and height while a frame is partly done
    task automatic shrink_midframe();
        set_config(1'($urandom_range(1)), 10'd10, 10'd6);
        repeat (25) send_word(KIND_PIXEL, rand_pixel());
        settle();
        write_reg(CFG_FRAME_WIDTH, 10'd4);
        write_reg(CFG_FRAME_HEIGHT, 10'd3);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_frame();
        while (sb.drain_pending)
            send_word(KIND_FLUSH, rand_pixel());
        settle();
    endtask

    function automatic cfg_data_t rand_width();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return cfg_data_t'($urandom_range(1));
        if (pick < 25)
            return cfg_data_t'($urandom_range(40, 13));
        return cfg_data_t'($urandom_range(12, 2));
    endfunction

    function automatic cfg_data_t rand_height();
        if ($urandom_range(99) < 10)
            return cfg_data_t'($urandom_range(1));
        return cfg_data_t'($urandom_range(6, 2));
    endfunction

    initial
    begin
        int phase_no;
        int spin;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_UNUSED, 10'h3FF);
        set_config(MODE_SHARPEN, 10'd3, 10'd3);
        send_word(KIND_FLUSH, 8'hFF);
        for (int i = 0; i < 9; i++)
            send_word(KIND_PIXEL, (i == 4) ? 8'hFF : 8'h00);
        repeat (4) send_word(KIND_FLUSH, 8'h00);
        settle();
        set_config(MODE_SOBEL_X, 10'd0, 10'd1);
        for (int i = 0; i < 4; i++)
            send_word(KIND_PIXEL, (i % 2 == 1) ? 8'hFF : 8'h00);
        send_word(KIND_FLUSH, 8'hA5);
        for (int i = 0; i < 4; i++)
            send_word(KIND_PIXEL, (i % 2 == 0) ? 8'hFF : 8'h00);
        repeat (2) send_word(KIND_FLUSH, 8'h5A);
        settle();

        tally_on = 1'b1;
        phase_no = 0;
        while (tally < ITEM_GOAL)
        begin
            steady <= (phase_no == 1);
            if (phase_no == 2 || phase_no == 4)
            begin
                tally_on = 1'b0;
                if (phase_no == 2)
                    run_phase(1'($urandom_range(1)), 10'd1023, 10'd1, 1);
                else
                    run_phase(1'($urandom_range(1)), 10'd1, 10'd512, 1);
                tally_on = 1'b1;
            end
            else if (phase_no == 3)
            begin
                hold_go <= ~hold_go;
                run_phase(1'($urandom_range(1)), 10'd8, 10'd5, 2);
            end
            else if (phase_no == 5)
                shrink_midframe();
            else
                run_phase(1'($urandom_range(1)), rand_width(), rand_height(),
                          $urandom_range(3, 1));
            phase_no++;
        end

        in_valid <= 1'b0;
        spin = 0;
        while (sb.pending() != 0 && spin < 10000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/esf_pkg.sv
sv/esf_ram.sv
sv/esf_col_cell.sv
sv/esf_kernel.sv
sv/edge_sharpen_3x3_stream_filter_core.sv
verif/tb_edge_sharpen_3x3_stream_filter_core.sv
